// ===== rtl/point_in_polygon_test_top_assert.svh =====
// Assertion macros for the point-in-polygon RTL.
`ifndef POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH

// Condition a at an edge requires condition c at the same edge.
`define PIP_ASSERT_IMPLIES(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error(msg);

// Condition a at an edge requires condition c at the next edge.
`define PIP_ASSERT_NEXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error(msg);

// Condition a never holds.
`define PIP_ASSERT_NEVER(label, clk, rstn, a, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(a)) \
        else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// Shared constants, codes and control structs of the point-in-polygon block.
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_BITS_DEF   = 16;

    // request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } pip_state_t;

    // sequencer to edge unit
    typedef struct packed {
        logic start;
        logic valid;
        logic last;
    } edge_ctl_t;

    // edge unit to sequencer
    typedef struct packed {
        logic done;
        logic odd;
    } edge_sts_t;

endpackage

// ===== rtl/pip_vmem.sv =====
// Vertex store: simple dual-port RAM with registered read data.
module pip_vmem #(
    parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
    parameter int WIDTH = 2 * pip_pkg::COORD_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pip_edge.sv =====
// Edge crossing unit: three-stage pipeline that counts ray crossings modulo two.
module pip_edge #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pip_pkg::edge_ctl_t           ctl,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output pip_pkg::edge_sts_t           sts
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // stage 1: span tests and differences of the upward-ordered edge
    logic                 swap;
    logic signed [COORD_BITS-1:0] lo_y, hi_y, hi_x, oax, oay, obx, oby;
    logic                 cond_next;
    logic signed [DW-1:0] dx1_next, dy_next, dyp_next, dx_next;

    logic                 e1_valid_reg, e1_last_reg, e1_cond_reg, e1_vert_reg;
    logic signed [DW-1:0] dx1_reg, dy_reg, dyp_reg, dx_reg;

    logic                 e2_valid_reg, e2_last_reg, e2_cond_reg, e2_vert_reg;
    logic signed [PW-1:0] prod_l_reg, prod_r_reg;
    logic signed [PW-1:0] prod_l_next, prod_r_next;

    logic hit;
    logic parity_reg, parity_next;
    logic done_reg;

    always_comb begin
        swap = ay > by;
        lo_y = swap ? by : ay;
        hi_y = swap ? ay : by;
        hi_x = (ax < bx) ? bx : ax;
        oax  = swap ? bx : ax;
        oay  = swap ? by : ay;
        obx  = swap ? ax : bx;
        oby  = swap ? ay : by;
        cond_next = (py > lo_y) && (py <= hi_y) && (px <= hi_x) && (ay != by);
        dx1_next  = DW'(px)  - DW'(oax);
        dy_next   = DW'(oby) - DW'(oay);
        dyp_next  = DW'(py)  - DW'(oay);
        dx_next   = DW'(obx) - DW'(oax);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
        end else begin
            e1_valid_reg <= ctl.valid;
        end
        e1_last_reg <= ctl.last;
        e1_cond_reg <= cond_next;
        e1_vert_reg <= (ax == bx);
        dx1_reg     <= dx1_next;
        dy_reg      <= dy_next;
        dyp_reg     <= dyp_next;
        dx_reg      <= dx_next;
    end

    // stage 2: cross products
    assign prod_l_next = PW'(dx1_reg) * PW'(dy_reg);
    assign prod_r_next = PW'(dyp_reg) * PW'(dx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_valid_reg <= 1'b0;
        end else begin
            e2_valid_reg <= e1_valid_reg;
        end
        e2_last_reg <= e1_last_reg;
        e2_cond_reg <= e1_cond_reg;
        e2_vert_reg <= e1_vert_reg;
        prod_l_reg  <= prod_l_next;
        prod_r_reg  <= prod_r_next;
    end

    // stage 3: decide and fold into parity
    assign hit = e2_cond_reg && (e2_vert_reg || (prod_l_reg <= prod_r_reg));

    always_comb begin
        parity_next = parity_reg;
        if (ctl.start) begin
            parity_next = 1'b0;
        end else if (e2_valid_reg) begin
            parity_next = parity_reg ^ hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            parity_reg <= parity_next;
            done_reg   <= e2_valid_reg && e2_last_reg;
        end
    end

    assign sts.done = done_reg;
    assign sts.odd  = parity_reg;

endmodule

// ===== rtl/pip_ctrl.sv =====
// Request sequencer: polygon count, bounding box, store walk and result register.
`include "point_in_polygon_test_top_assert.svh"

module pip_ctrl #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_req,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_inside,
    output logic [1:0]                   out_status,
    output pip_pkg::edge_ctl_t           edge_ctl,
    output logic signed [COORD_BITS-1:0] edge_ax,
    output logic signed [COORD_BITS-1:0] edge_ay,
    output logic signed [COORD_BITS-1:0] edge_bx,
    output logic signed [COORD_BITS-1:0] edge_by,
    output logic signed [COORD_BITS-1:0] edge_px,
    output logic signed [COORD_BITS-1:0] edge_py,
    input  pip_pkg::edge_sts_t           edge_sts
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int MW = 2 * COORD_BITS;

    pip_pkg::pip_state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [COORD_BITS-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic signed [COORD_BITS-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic signed [COORD_BITS-1:0] pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic rd_valid_reg, rd_valid_next, rd_first_reg, rd_first_next;
    logic rd_last_reg, rd_last_next;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic res_inside_reg, res_inside_next;
    logic [1:0] res_status_reg, res_status_next;
    logic out_valid_reg, out_valid_next;
    logic out_inside_reg, out_inside_next;
    logic [1:0] out_status_reg, out_status_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_rdata;
    logic          accept, in_box, start;

    pip_vmem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MW),
        .AW    (AW)
    ) u_vmem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({in_y, in_x}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept = in_valid && in_ready;
    assign in_box = (in_x >= min_x_reg) && (in_x <= max_x_reg) &&
                    (in_y >= min_y_reg) && (in_y <= max_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pip_pkg::ST_IDLE;
            cnt_reg       <= '0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
        pt_x_reg       <= pt_x_next;
        pt_y_reg       <= pt_y_next;
        idx_reg        <= idx_next;
        rd_first_reg   <= rd_first_next;
        rd_last_reg    <= rd_last_next;
        res_inside_reg <= res_inside_next;
        res_status_reg <= res_status_next;
        out_inside_reg <= out_inside_next;
        out_status_reg <= out_status_next;
        if (rd_valid_reg) begin
            prev_x_reg <= mem_rdata[COORD_BITS-1:0];
            prev_y_reg <= mem_rdata[MW-1:COORD_BITS];
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        min_x_next      = min_x_reg;
        max_x_next      = max_x_reg;
        min_y_next      = min_y_reg;
        max_y_next      = max_y_reg;
        pt_x_next       = pt_x_reg;
        pt_y_next       = pt_y_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        rd_first_next   = rd_first_reg;
        rd_last_next    = rd_last_reg;
        res_inside_next = res_inside_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_inside_next = out_inside_reg;
        out_status_next = out_status_reg;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[AW-1:0];
        mem_re          = 1'b0;
        mem_raddr       = idx_reg[AW-1:0];
        start           = 1'b0;

        case (state_reg)
            pip_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_inside_next = 1'b0;
                    res_status_next = pip_pkg::STS_OK;
                    state_next      = pip_pkg::ST_DONE;
                    case (in_req)
                        pip_pkg::REQ_CLEAR: begin
                            cnt_next   = '0;
                            min_x_next = '0;
                            max_x_next = '0;
                            min_y_next = '0;
                            max_y_next = '0;
                        end
                        pip_pkg::REQ_APPEND: begin
                            if (cnt_reg == CW'(MAX_VERTICES)) begin
                                res_status_next = pip_pkg::STS_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                if (cnt_reg == '0) begin
                                    min_x_next = in_x;
                                    max_x_next = in_x;
                                    min_y_next = in_y;
                                    max_y_next = in_y;
                                end else begin
                                    if (in_x < min_x_reg) min_x_next = in_x;
                                    if (in_x > max_x_reg) max_x_next = in_x;
                                    if (in_y < min_y_reg) min_y_next = in_y;
                                    if (in_y > max_y_reg) max_y_next = in_y;
                                end
                            end
                        end
                        pip_pkg::REQ_QUERY: begin
                            pt_x_next = in_x;
                            pt_y_next = in_y;
                            if (cnt_reg == '0) begin
                                res_status_next = pip_pkg::STS_EMPTY;
                            end else if (in_box) begin
                                start      = 1'b1;
                                idx_next   = '0;
                                state_next = pip_pkg::ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pip_pkg::ST_WALK: begin
                // read vertices 0..n-1, then vertex 0 again for the closing edge
                mem_re        = 1'b1;
                rd_valid_next = 1'b1;
                rd_first_next = (idx_reg == '0);
                rd_last_next  = (idx_reg == cnt_reg);
                if (idx_reg == cnt_reg) begin
                    mem_raddr  = '0;
                    state_next = pip_pkg::ST_DRAIN;
                end
                idx_next = idx_reg + 1'b1;
            end
            pip_pkg::ST_DRAIN: begin
                if (edge_sts.done) begin
                    res_inside_next = edge_sts.odd;
                    res_status_next = pip_pkg::STS_OK;
                    state_next      = pip_pkg::ST_DONE;
                end
            end
            pip_pkg::ST_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_inside_next = res_inside_reg;
                    out_status_next = res_status_reg;
                    state_next      = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    assign edge_ctl.start = start;
    assign edge_ctl.valid = rd_valid_reg && !rd_first_reg;
    assign edge_ctl.last  = rd_last_reg;
    assign edge_ax = prev_x_reg;
    assign edge_ay = prev_y_reg;
    assign edge_bx = mem_rdata[COORD_BITS-1:0];
    assign edge_by = mem_rdata[MW-1:COORD_BITS];
    assign edge_px = pt_x_reg;
    assign edge_py = pt_y_reg;

    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;
    assign out_status = out_status_reg;

    `PIP_ASSERT_IMPLIES(a_wr_idle, aclk, aresetn, mem_we, accept, "store write without request")
    `PIP_ASSERT_IMPLIES(a_done_drain, aclk, aresetn, edge_sts.done, state_reg == pip_pkg::ST_DRAIN, "edge result outside drain")
    `PIP_ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > CW'(MAX_VERTICES), "vertex count overflow")
    `PIP_ASSERT_IMPLIES(a_walk_idx, aclk, aresetn, state_reg == pip_pkg::ST_WALK, idx_reg <= cnt_reg, "walk index past count")
    `PIP_ASSERT_NEXT(a_last_drain, aclk, aresetn, state_reg == pip_pkg::ST_WALK && idx_reg == cnt_reg, state_reg == pip_pkg::ST_DRAIN, "walk did not end after closing read")

endmodule

// ===== rtl/point_in_polygon_test_top.sv =====
// Top level of the point-in-polygon test block with stream ports.
// Clear, append, unused codes and queries that end early (empty polygon, outside the box)
// go to the result register and then m_tvalid; a query that walks n vertices first drains
// the crossing pipeline. No request is taken before the last result is in the output
// register; a walk is bound by the store's single read port; a stalled m_tready holds the sequencer.
// aresetn (synchronous, active low) empties the polygon and zeroes the box; no clearing pass.
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel, word rounded up to whole bytes
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((2 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata, // req_type, coord_x, coord_y, zero fill
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata    // is_inside, status, zero fill
);

    logic [1:0]                   req_type;
    logic signed [COORD_BITS-1:0] coord_x, coord_y;
    logic                         is_inside;
    logic [1:0]                   status;

    pip_pkg::edge_ctl_t edge_ctl;
    pip_pkg::edge_sts_t edge_sts;
    logic signed [COORD_BITS-1:0] edge_ax, edge_ay, edge_bx, edge_by, edge_px, edge_py;

    // unpack the request word, lowest field first
    assign req_type = s_tdata[1:0];
    assign coord_x  = s_tdata[COORD_BITS+1:2];
    assign coord_y  = s_tdata[2*COORD_BITS+1:COORD_BITS+2];

    // sequencer: owns the vertex store, count, box and the result register
    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (req_type),
        .in_x       (coord_x),
        .in_y       (coord_y),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_inside (is_inside),
        .out_status (status),
        .edge_ctl   (edge_ctl),
        .edge_ax    (edge_ax),
        .edge_ay    (edge_ay),
        .edge_bx    (edge_bx),
        .edge_by    (edge_by),
        .edge_px    (edge_px),
        .edge_py    (edge_py),
        .edge_sts   (edge_sts)
    );

    // crossing pipeline: one edge per cycle, parity of the crossings at the end
    pip_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (edge_ctl),
        .ax      (edge_ax),
        .ay      (edge_ay),
        .bx      (edge_bx),
        .by      (edge_by),
        .px      (edge_px),
        .py      (edge_py),
        .sts     (edge_sts)
    );

    // pack the result: is_inside in bit 0, status above it, zero fill
    assign m_tdata = {5'd0, status, is_inside};

endmodule
